[src/tsw_pkg.sv]
// Shared constants, types and tables for the terrain splat weighting core.
package tsw_pkg;

  // Field widths
  localparam int HEIGHT_W    = 16;
  localparam int WEIGHT_W    = 16;
  localparam int WEIGHT_FRAC = 15;
  localparam int SLOPE_W     = 15;
  localparam int Q16_W       = 17;  // Q0.16 values that may reach one

  localparam logic [Q16_W-1:0]    Q16_ONE    = 17'd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'(1 << WEIGHT_FRAC);

  // Pipelined restoring divider: one quotient bit per stage
  localparam int DIV_STAGES = 17;
  localparam int DIV_NUM_W  = 35;
  localparam int DIV_DEN_W  = 18;

  // Square root: one root bit per stage
  localparam int SQRT_STAGES = 25;
  localparam int SQRT_REM_W  = 50;

  // Vectoring arctangent
  localparam int CORDIC_STAGES = 18;
  localparam int CORDIC_XY_W   = 28;
  localparam int CORDIC_Z_W    = 25;
  localparam logic [22:0] ANGLE_MAX = 23'd5898240;  // 90 deg, Q16.16

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_AUTO_SPLAT  = 3'd0,
    CFG_CELL_SIZE   = 3'd1,
    CFG_MAX_HEIGHT  = 3'd2,
    CFG_ROCK_SLOPE  = 3'd3,
    CFG_SPLAT_BLEND = 3'd4,
    CFG_SNOW_FRAC   = 3'd5,
    CFG_SHORE_FRAC  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        auto_splat;
    logic [15:0] cell_size;
    logic [15:0] max_height;
    logic [14:0] rock_slope_deg;
    logic [15:0] splat_blend;
    logic [15:0] snow_height_frac;
    logic [15:0] shore_height_frac;
  } cfg_t;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [CORDIC_Z_W-2:0] atan_deg(input logic [4:0] i);
    logic [CORDIC_Z_W-2:0] a;
    unique case (i)
      5'd0:    a = 24'd2949120;
      5'd1:    a = 24'd1740967;
      5'd2:    a = 24'd919879;
      5'd3:    a = 24'd466945;
      5'd4:    a = 24'd234379;
      5'd5:    a = 24'd117304;
      5'd6:    a = 24'd58666;
      5'd7:    a = 24'd29335;
      5'd8:    a = 24'd14668;
      5'd9:    a = 24'd7334;
      5'd10:   a = 24'd3667;
      5'd11:   a = 24'd1833;
      5'd12:   a = 24'd917;
      5'd13:   a = 24'd458;
      5'd14:   a = 24'd229;
      5'd15:   a = 24'd115;
      5'd16:   a = 24'd57;
      5'd17:   a = 24'd29;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[src/tsw_div_pipe.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
module tsw_div_pipe (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [tsw_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [tsw_pkg::DIV_DEN_W-1:0]    den_i,
  output logic [tsw_pkg::DIV_STAGES-1:0]   quo_o
);

  localparam int NS = tsw_pkg::DIV_STAGES;

  logic [tsw_pkg::DIV_NUM_W-1:0] rem_q [NS-1];
  logic [tsw_pkg::DIV_DEN_W-1:0] den_q [NS-1];
  logic [NS-1:0]                 quo_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K = NS - 1 - s;
    logic [tsw_pkg::DIV_NUM_W-1:0] rem_in;
    logic [tsw_pkg::DIV_NUM_W-1:0] sub;
    logic [tsw_pkg::DIV_DEN_W-1:0] den_in;
    logic [NS-1:0]                 quo_in;
    logic                          ge;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // trial subtract of the shifted divisor
    assign sub = tsw_pkg::DIV_NUM_W'(den_in) << K;
    assign ge  = rem_in >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= quo_in | (NS'(ge) << K);
      end
    end

    if (s < NS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? rem_in - sub : rem_in;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

[src/tsw_slope.sv]
// Slope stage: central differences, gradient length and arctangent to Q8.8 degrees.
module tsw_slope (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [15:0]                   cell_size_i,
  input  logic                          valid_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_center_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_left_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_right_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_up_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_down_i,
  output logic                          valid_o,
  output logic [tsw_pkg::SLOPE_W-1:0]   slope_o,
  output logic [tsw_pkg::HEIGHT_W-1:0]  hc_o
);

  localparam int NQ = tsw_pkg::SQRT_STAGES;
  localparam int NC = tsw_pkg::CORDIC_STAGES;
  localparam int RW = tsw_pkg::SQRT_REM_W;
  localparam int XW = tsw_pkg::CORDIC_XY_W;
  localparam int ZW = tsw_pkg::CORDIC_Z_W;

  // Differences
  logic               va_q;
  logic signed [16:0] ex_q, ez_q;
  logic [15:0]        hca_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q  <= $signed({1'b0, height_right_i}) - $signed({1'b0, height_left_i});
      ez_q  <= $signed({1'b0, height_down_i}) - $signed({1'b0, height_up_i});
      hca_q <= height_center_i;
    end
  end

  // Squares
  logic               vb_q;
  logic [31:0]        ex2_q, ez2_q;
  logic [15:0]        hcb_q;
  logic signed [33:0] ex_w, ez_w, ex_p, ez_p;

  assign ex_w = 34'(ex_q);
  assign ez_w = 34'(ez_q);
  assign ex_p = ex_w * ex_w;
  assign ez_p = ez_w * ez_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex2_q <= ex_p[31:0];
      ez2_q <= ez_p[31:0];
      hcb_q <= hca_q;
    end
  end

  // Sum of squares
  logic        vc_q;
  logic [32:0] sq_q;
  logic [15:0] hcc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= 33'(ex2_q) + 33'(ez2_q);
      hcc_q <= hcb_q;
    end
  end

  // Square root of sq << 16, one root bit per stage
  logic [RW-1:0] srem_q [NQ-1];
  logic [NQ-1:0] srt_q  [NQ];
  logic          sv_q   [NQ];
  logic [15:0]   shc_q  [NQ];

  for (genvar s = 0; s < NQ; s++) begin : g_sqrt
    localparam int K = NQ - 1 - s;
    logic [RW-1:0] rem_in, trial;
    logic [NQ-1:0] rt_in;
    logic          v_in, ge;
    logic [15:0]   hc_in;

    if (s == 0) begin : g_first
      assign rem_in = RW'({sq_q, 16'b0});
      assign rt_in  = '0;
      assign v_in   = vc_q;
      assign hc_in  = hcc_q;
    end else begin : g_next
      assign rem_in = srem_q[s-1];
      assign rt_in  = srt_q[s-1];
      assign v_in   = sv_q[s-1];
      assign hc_in  = shc_q[s-1];
    end

    // (r + 2^k)^2 - r^2
    assign trial = (RW'(rt_in) << (K + 1)) + (RW'(1) << (2 * K));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[s] <= 1'b0;
      end else if (en_i) begin
        sv_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srt_q[s] <= ge ? (rt_in | (NQ'(1) << K)) : rt_in;
        shc_q[s] <= hc_in;
      end
    end

    if (s < NQ - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          srem_q[s] <= ge ? rem_in - trial : rem_in;
        end
      end
    end
  end

  // Vectoring arctangent of mag / (2 * cell << 8)
  logic [15:0]          cell_len;
  logic [NQ-1:0]        mag;
  logic signed [XW-1:0] cx_q [NC-1];
  logic signed [XW-1:0] cy_q [NC-1];
  logic signed [ZW-1:0] cz_q [NC];
  logic                 cv_q [NC];
  logic                 cmz_q [NC];
  logic [15:0]          chc_q [NC];

  assign cell_len = (cell_size_i == '0) ? 16'd256 : cell_size_i;
  assign mag      = srt_q[NQ-1];

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic signed [XW-1:0] x_in, y_in, xs, ys;
    logic signed [ZW-1:0] z_in, ang;
    logic                 v_in, mz_in, pos;
    logic [15:0]          hc_in;

    if (i == 0) begin : g_first
      assign x_in  = $signed(XW'({cell_len, 9'b0}));
      assign y_in  = $signed(XW'(mag));
      assign z_in  = '0;
      assign v_in  = sv_q[NQ-1];
      assign mz_in = (mag == '0);
      assign hc_in = shc_q[NQ-1];
    end else begin : g_next
      assign x_in  = cx_q[i-1];
      assign y_in  = cy_q[i-1];
      assign z_in  = cz_q[i-1];
      assign v_in  = cv_q[i-1];
      assign mz_in = cmz_q[i-1];
      assign hc_in = chc_q[i-1];
    end

    assign xs  = x_in >>> i;
    assign ys  = y_in >>> i;
    assign pos = y_in > 0;
    assign ang = $signed({1'b0, tsw_pkg::atan_deg(5'(i))});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i] <= 1'b0;
      end else if (en_i) begin
        cv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cz_q[i]  <= pos ? z_in + ang : z_in - ang;
        cmz_q[i] <= mz_in;
        chc_q[i] <= hc_in;
      end
    end

    if (i < NC - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          cx_q[i] <= pos ? x_in + ys : x_in - ys;
          cy_q[i] <= pos ? y_in - xs : y_in + xs;
        end
      end
    end
  end

  // Clamp to [0, 90 deg] and round to Q8.8
  logic                 fv_q;
  logic [15:0]          fhc_q;
  logic [tsw_pkg::SLOPE_W-1:0] fslope_q;
  logic signed [ZW-1:0] zf;
  logic [22:0]          zcl, zrnd;

  assign zf = cz_q[NC-1];

  always_comb begin
    if (zf < 0) begin
      zcl = '0;
    end else if (zf > $signed(ZW'(tsw_pkg::ANGLE_MAX))) begin
      zcl = tsw_pkg::ANGLE_MAX;
    end else begin
      zcl = zf[22:0];
    end
    zrnd = zcl + 23'd128;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en_i) begin
      fv_q <= cv_q[NC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fslope_q <= cmz_q[NC-1] ? '0 : zrnd[22:8];
      fhc_q    <= chc_q[NC-1];
    end
  end

  assign valid_o = fv_q;
  assign slope_o = fslope_q;
  assign hc_o    = fhc_q;

endmodule

[src/tsw_smooth.sv]
// Height fraction and the three smoothstep blends (rock, snow, shore).
module tsw_smooth (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  tsw_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  input  logic [tsw_pkg::SLOPE_W-1:0]   slope_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  hc_i,
  output logic                          valid_o,
  output logic [tsw_pkg::Q16_W-1:0]     rock_o,
  output logic [tsw_pkg::Q16_W-1:0]     snow_o,
  output logic [tsw_pkg::Q16_W-1:0]     shore_o
);

  localparam int ND = tsw_pkg::DIV_STAGES;
  localparam int QW = tsw_pkg::Q16_W;

  // Blend ranges from the configuration, refreshed every cycle
  logic [30:0]        bprod;
  logic [14:0]        bs_raw;
  logic [14:0]        bs_q;
  logic [15:0]        bh_q;
  logic signed [18:0] lo_q [3];
  logic signed [18:0] hi_q [3];
  logic [16:0]        den_q [3];

  assign bprod  = 31'(cfg_i.rock_slope_deg) * 31'(cfg_i.splat_blend);
  assign bs_raw = bprod[30:16];

  always_ff @(posedge clk_i) begin
    bs_q     <= (bs_raw < 15'd256) ? 15'd256 : bs_raw;
    bh_q     <= (cfg_i.splat_blend < 16'd655) ? 16'd655 : cfg_i.splat_blend;
    lo_q[0]  <= $signed(19'(cfg_i.rock_slope_deg)) - $signed(19'(bs_q));
    hi_q[0]  <= $signed(19'(cfg_i.rock_slope_deg)) + $signed(19'(bs_q));
    den_q[0] <= 17'({bs_q, 1'b0});
    lo_q[1]  <= $signed(19'(cfg_i.snow_height_frac)) - $signed(19'(bh_q));
    hi_q[1]  <= $signed(19'(cfg_i.snow_height_frac)) + $signed(19'(bh_q));
    den_q[1] <= {bh_q, 1'b0};
    lo_q[2]  <= $signed(19'(cfg_i.shore_height_frac)) - $signed(19'(bh_q));
    hi_q[2]  <= $signed(19'(cfg_i.shore_height_frac)) + $signed(19'(bh_q));
    den_q[2] <= {bh_q, 1'b0};
  end

  // Height fraction division, saturated above the useful range
  logic [ND-1:0]              hquo;
  logic                       hzero, hsat;
  logic                       hv_q  [ND];
  logic                       hz_q  [ND];
  logic                       hs_q  [ND];
  logic [tsw_pkg::SLOPE_W-1:0] hsl_q [ND];

  assign hzero = (cfg_i.max_height == '0);
  assign hsat  = {1'b0, hc_i} >= {cfg_i.max_height, 1'b0};

  tsw_div_pipe u_hdiv (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (tsw_pkg::DIV_NUM_W'({hc_i, 16'b0})),
    .den_i (tsw_pkg::DIV_DEN_W'(cfg_i.max_height)),
    .quo_o (hquo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ND; j++) hv_q[j] <= 1'b0;
    end else if (en_i) begin
      hv_q[0] <= valid_i;
      for (int j = 1; j < ND; j++) hv_q[j] <= hv_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hz_q[0]  <= hzero;
      hs_q[0]  <= hsat;
      hsl_q[0] <= slope_i;
      for (int j = 1; j < ND; j++) begin
        hz_q[j]  <= hz_q[j-1];
        hs_q[j]  <= hs_q[j-1];
        hsl_q[j] <= hsl_q[j-1];
      end
    end
  end

  logic                        fv_q;
  logic [QW-1:0]               hf_q;
  logic [tsw_pkg::SLOPE_W-1:0] sl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en_i) begin
      fv_q <= hv_q[ND-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (hz_q[ND-1]) begin
        hf_q <= '0;
      end else if (hs_q[ND-1]) begin
        hf_q <= '1;
      end else begin
        hf_q <= hquo;
      end
      sl_q <= hsl_q[ND-1];
    end
  end

  // Valid chain through the smoothstep lanes
  logic dv_q [ND];
  logic v1_q, v2_q, v3_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ND; j++) dv_q[j] <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= fv_q;
      for (int j = 1; j < ND; j++) dv_q[j] <= dv_q[j-1];
      v1_q <= dv_q[ND-1];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  logic [QW-1:0] res [3];

  // lane 0: rock over slope, lanes 1 and 2: snow and shore over height
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [18:0] x, diff;
    logic               below, above;
    logic [ND-1:0]      quo;
    logic               lb_q [ND];
    logic               la_q [ND];
    logic [QW-1:0]      t_q, t2_q, r_q;
    logic [32:0]        tt_q;
    logic [49:0]        p_q;
    logic [17:0]        k3;
    logic [33:0]        tt;
    logic [49:0]        rsum;

    if (l == 0) begin : g_rock
      assign x = $signed(19'(sl_q));
    end else begin : g_height
      assign x = $signed(19'(hf_q));
    end

    assign diff  = x - lo_q[l];
    assign below = x <= lo_q[l];
    assign above = x >= hi_q[l];

    tsw_div_pipe u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (tsw_pkg::DIV_NUM_W'({diff[17:0], 16'b0})),
      .den_i (tsw_pkg::DIV_DEN_W'(den_q[l])),
      .quo_o (quo)
    );

    assign tt   = 34'(t_q) * 34'(t_q);
    assign k3   = 18'd196608 - 18'({t2_q, 1'b0});
    assign rsum = p_q + 50'd2147483648;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lb_q[0] <= below;
        la_q[0] <= above;
        for (int j = 1; j < ND; j++) begin
          lb_q[j] <= lb_q[j-1];
          la_q[j] <= la_q[j-1];
        end
        // t = clamp((x - lo) / (hi - lo))
        if (lb_q[ND-1]) begin
          t_q <= '0;
        end else if (la_q[ND-1]) begin
          t_q <= tsw_pkg::Q16_ONE;
        end else begin
          t_q <= quo;
        end
        tt_q <= tt[32:0];
        t2_q <= t_q;
        p_q  <= 50'(tt_q) * 50'(k3);
        r_q  <= rsum[48:32];
      end
    end

    assign res[l] = r_q;
  end

  assign valid_o = v4_q;
  assign rock_o  = res[0];
  assign snow_o  = res[1];
  assign shore_o = res[2];

endmodule

[src/tsw_mix.sv]
// Layer mixing: snow and shore scaled by flatness, base remainder, normalization.
module tsw_mix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          auto_splat_i,
  input  logic                          valid_i,
  input  logic [tsw_pkg::Q16_W-1:0]     rock_i,
  input  logic [tsw_pkg::Q16_W-1:0]     snow_i,
  input  logic [tsw_pkg::Q16_W-1:0]     shore_i,
  output logic                          valid_o,
  output logic [tsw_pkg::WEIGHT_W-1:0]  weight_base_o,
  output logic [tsw_pkg::WEIGHT_W-1:0]  weight_rock_o,
  output logic [tsw_pkg::WEIGHT_W-1:0]  weight_snow_o,
  output logic [tsw_pkg::WEIGHT_W-1:0]  weight_shore_o
);

  localparam int ND = tsw_pkg::DIV_STAGES;
  localparam int QW = tsw_pkg::Q16_W;
  localparam int WW = tsw_pkg::WEIGHT_W;

  // Scale snow and shore by flatness
  logic [QW-1:0] flat, nshore;
  logic [33:0]   ps, pr;
  logic          v0_q;
  logic [32:0]   ps_q, pr_q;
  logic [QW-1:0] rock0_q;

  assign flat   = tsw_pkg::Q16_ONE - rock_i;
  assign nshore = tsw_pkg::Q16_ONE - shore_i;
  assign ps     = 34'(snow_i) * 34'(flat);
  assign pr     = 34'(nshore) * 34'(flat);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ps_q    <= ps[32:0];
      pr_q    <= pr[32:0];
      rock0_q <= rock_i;
    end
  end

  // Round, base remainder and sum
  logic [33:0]        snow_r, shore_r;
  logic [QW-1:0]      snow_w, shore_w, base_w;
  logic signed [19:0] base_s;
  logic               v1_q;
  logic [QW-1:0]      w_q [4];
  logic [17:0]        sum_q;

  assign snow_r  = 34'(ps_q) + 34'd32768;
  assign shore_r = 34'(pr_q) + 34'd32768;
  assign snow_w  = snow_r[32:16];
  assign shore_w = shore_r[32:16];
  assign base_s  = $signed(20'(tsw_pkg::Q16_ONE)) - $signed(20'(rock0_q))
                   - $signed(20'(snow_w)) - $signed(20'(shore_w));
  assign base_w  = (base_s < 0) ? '0 : base_s[QW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q[0] <= base_w;
      w_q[1] <= rock0_q;
      w_q[2] <= snow_w;
      w_q[3] <= shore_w;
      sum_q  <= 18'(base_w) + 18'(rock0_q) + 18'(snow_w) + 18'(shore_w);
    end
  end

  // Valid chain
  logic dv_q [ND];
  logic vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      for (int j = 0; j < ND; j++) dv_q[j] <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v0_q    <= valid_i;
      v1_q    <= v0_q;
      dv_q[0] <= v1_q;
      for (int j = 1; j < ND; j++) dv_q[j] <= dv_q[j-1];
      vo_q    <= dv_q[ND-1];
    end
  end

  // Rounded normalization: (w * one + sum / 2) / sum
  logic [WW-1:0] wo_q [4];

  for (genvar l = 0; l < 4; l++) begin : g_norm
    logic [tsw_pkg::DIV_NUM_W-1:0] num;
    logic [ND-1:0]                 quo;

    assign num = tsw_pkg::DIV_NUM_W'({w_q[l], {tsw_pkg::WEIGHT_FRAC{1'b0}}})
                 + tsw_pkg::DIV_NUM_W'(sum_q[17:1]);

    tsw_div_pipe u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (num),
      .den_i (tsw_pkg::DIV_DEN_W'(sum_q)),
      .quo_o (quo)
    );

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!auto_splat_i) begin
          wo_q[l] <= (l == 0) ? tsw_pkg::WEIGHT_ONE : '0;
        end else begin
          wo_q[l] <= quo[WW-1:0];
        end
      end
    end
  end

  assign valid_o        = vo_q;
  assign weight_base_o  = wo_q[0];
  assign weight_rock_o  = wo_q[1];
  assign weight_snow_o  = wo_q[2];
  assign weight_shore_o = wo_q[3];

endmodule

[src/terrain_splat_weighting_core.sv]
// Top level of the terrain splat weighting core: config registers, pipeline, output skid.
//
// Takes one heightmap cell (center plus four clamped neighbors, unsigned Q8.8) per
// transaction and returns four Q1.15 texture weights (base, rock, snow, shore).
// The core accepts one cell every clock cycle while in_stall_o is low. Its pipeline
// depth is set by the 25-stage square root, the 18-stage arctangent and three
// rows of 17-stage dividers (height fraction, smoothstep, normalization). When the
// downstream side stalls, one result parks in a skid register and the whole
// pipeline then holds; in_stall_o is driven straight from that skid register.
// Configuration writes are always ready and must only be issued while no cell is in
// flight.
module terrain_splat_weighting_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  // input cells
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_center_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_left_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_right_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_up_i,
  input  logic [tsw_pkg::HEIGHT_W-1:0]  height_down_i,
  // output weights
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tsw_pkg::WEIGHT_W-1:0]  weight_base_o,
  output logic [tsw_pkg::WEIGHT_W-1:0]  weight_rock_o,
  output logic [tsw_pkg::WEIGHT_W-1:0]  weight_snow_o,
  output logic [tsw_pkg::WEIGHT_W-1:0]  weight_shore_o
);

  localparam int WW = tsw_pkg::WEIGHT_W;

  // Configuration registers
  tsw_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_splat        <= 1'b1;
      cfg_q.cell_size         <= 16'd256;
      cfg_q.max_height        <= 16'd25600;
      cfg_q.rock_slope_deg    <= 15'd8960;
      cfg_q.splat_blend       <= 16'd3277;
      cfg_q.snow_height_frac  <= 16'd45875;
      cfg_q.shore_height_frac <= 16'd6554;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tsw_pkg::cfg_idx_e'(cfg_index_i))
        tsw_pkg::CFG_AUTO_SPLAT:  cfg_q.auto_splat        <= cfg_data_i[0];
        tsw_pkg::CFG_CELL_SIZE:   cfg_q.cell_size         <= cfg_data_i;
        tsw_pkg::CFG_MAX_HEIGHT:  cfg_q.max_height        <= cfg_data_i;
        tsw_pkg::CFG_ROCK_SLOPE:  cfg_q.rock_slope_deg    <= cfg_data_i[14:0];
        tsw_pkg::CFG_SPLAT_BLEND: cfg_q.splat_blend       <= cfg_data_i;
        tsw_pkg::CFG_SNOW_FRAC:   cfg_q.snow_height_frac  <= cfg_data_i;
        tsw_pkg::CFG_SHORE_FRAC:  cfg_q.shore_height_frac <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advances unless the skid register is occupied
  logic skid_full_q;
  logic en;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  logic                        sl_valid;
  logic [tsw_pkg::SLOPE_W-1:0] sl_slope;
  logic [tsw_pkg::HEIGHT_W-1:0] sl_hc;

  tsw_slope u_slope (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .cell_size_i     (cfg_q.cell_size),
    .valid_i         (in_valid_i),
    .height_center_i (height_center_i),
    .height_left_i   (height_left_i),
    .height_right_i  (height_right_i),
    .height_up_i     (height_up_i),
    .height_down_i   (height_down_i),
    .valid_o         (sl_valid),
    .slope_o         (sl_slope),
    .hc_o            (sl_hc)
  );

  logic                      sm_valid;
  logic [tsw_pkg::Q16_W-1:0] sm_rock, sm_snow, sm_shore;

  tsw_smooth u_smooth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (sl_valid),
    .slope_i (sl_slope),
    .hc_i    (sl_hc),
    .valid_o (sm_valid),
    .rock_o  (sm_rock),
    .snow_o  (sm_snow),
    .shore_o (sm_shore)
  );

  logic          mx_valid;
  logic [WW-1:0] mx_w [4];

  tsw_mix u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .auto_splat_i   (cfg_q.auto_splat),
    .valid_i        (sm_valid),
    .rock_i         (sm_rock),
    .snow_i         (sm_snow),
    .shore_i        (sm_shore),
    .valid_o        (mx_valid),
    .weight_base_o  (mx_w[0]),
    .weight_rock_o  (mx_w[1]),
    .weight_snow_o  (mx_w[2]),
    .weight_shore_o (mx_w[3])
  );

  // Output register with one-entry skid
  logic          out_valid_q;
  logic [WW-1:0] out_w_q  [4];
  logic [WW-1:0] skid_w_q [4];
  logic          out_take;

  assign out_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (!out_stall_i) begin
        skid_full_q <= 1'b0;
      end
    end else if (out_take) begin
      out_valid_q <= mx_valid;
    end else if (mx_valid) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (!out_stall_i) begin
        out_w_q <= skid_w_q;
      end
    end else if (out_take) begin
      out_w_q <= mx_w;
    end else if (mx_valid) begin
      skid_w_q <= mx_w;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign weight_base_o  = out_w_q[0];
  assign weight_rock_o  = out_w_q[1];
  assign weight_snow_o  = out_w_q[2];
  assign weight_shore_o = out_w_q[3];

`ifndef SYNTH
  // skid holds data only behind a waiting output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid occupied with empty output register");

  // skid fills whenever a new result meets a stalled output
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_full_q && out_valid_q && out_stall_i && mx_valid |=> skid_full_q)
    else $error("result lost at stalled output");

  // base-only weights when auto splat is off
  a_base_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cfg_q.auto_splat |->
      weight_base_o == tsw_pkg::WEIGHT_ONE && weight_rock_o == '0 &&
      weight_snow_o == '0 && weight_shore_o == '0)
    else $error("non-base weight with auto splat off");
`endif

endmodule
